@@ src/owrs_pkg.sv @@
// Shared types and constants for the ROM search engine.
package owrs_pkg;

  localparam int ROM_WIDTH    = 64;
  localparam int POS_WIDTH    = 7;
  localparam int FAM_WIDTH    = 4;
  localparam int FAMILY_LIMIT = 9;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BIT   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_DIR     = 3'd0,
    ST_BEGUN   = 3'd1,
    ST_FOUND   = 3'd2,
    ST_NONE    = 3'd3,
    ST_IGNORED = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

endpackage

@@ src/one_wire_rom_search.sv @@
// ROM search engine: one item in, one registered result out.
// Each accepted item updates the search state and loads the result register
// at the same clock edge; the result is valid in the cycle after acceptance.
// Throughput is one item per cycle while out_ready stays high; a result that
// waits to be taken holds in_ready low until it leaves.
// Reset (rst, synchronous, active high) clears the address, discrepancies,
// last-device flag and pass, sets the bit position to one, drops any result.
module one_wire_rom_search
  import owrs_pkg::*;
#(
  parameter int ROM_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic                 presence,
  input  logic                 id_bit,
  input  logic                 complement_bit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic                 direction,
  output logic [ROM_WIDTH-1:0] rom_address,
  output logic                 last_device,
  output logic [FAM_WIDTH-1:0] family_discrepancy
);

  localparam int SEARCH_BITS = ROM_BYTES * 8;

  logic [ROM_WIDTH-1:0] rom_bits, rom_bits_next;
  logic [POS_WIDTH-1:0] last_discrepancy, last_discrepancy_next;
  logic [FAM_WIDTH-1:0] family_discrepancy_reg, family_discrepancy_reg_next;
  logic                 last_device_flag, last_device_flag_next;
  logic [POS_WIDTH-1:0] bit_position, bit_position_next;
  logic [POS_WIDTH-1:0] last_zero_pos, last_zero_pos_next;
  logic                 pass_active, pass_active_next;

  status_t              status_next;
  logic                 dir_next;
  logic                 abort_last;
  logic [POS_WIDTH-1:0] pos_minus;
  logic [5:0]           bit_idx;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_minus = bit_position - POS_WIDTH'(1);
  assign bit_idx   = pos_minus[5:0];

  always_comb begin
    rom_bits_next               = rom_bits;
    last_discrepancy_next       = last_discrepancy;
    family_discrepancy_reg_next = family_discrepancy_reg;
    last_device_flag_next       = last_device_flag;
    bit_position_next           = bit_position;
    last_zero_pos_next          = last_zero_pos;
    pass_active_next            = pass_active;
    status_next                 = ST_IGNORED;
    dir_next                    = 1'b0;
    abort_last                  = 1'b0;
    case (mode_t'(mode))
      MODE_START: begin
        pass_active_next = 1'b0;
        if (last_device_flag) begin
          last_discrepancy_next       = '0;
          last_device_flag_next       = 1'b0;
          family_discrepancy_reg_next = '0;
          status_next                 = ST_NONE;
          abort_last                  = 1'b1;
        end else if (!presence) begin
          last_discrepancy_next       = '0;
          last_device_flag_next       = 1'b0;
          family_discrepancy_reg_next = '0;
          status_next                 = ST_NONE;
        end else begin
          pass_active_next   = 1'b1;
          bit_position_next  = POS_WIDTH'(1);
          last_zero_pos_next = '0;
          status_next        = ST_BEGUN;
        end
      end
      MODE_BIT: begin
        if (pass_active) begin
          if (id_bit && complement_bit) begin
            pass_active_next            = 1'b0;
            last_discrepancy_next       = '0;
            last_device_flag_next       = 1'b0;
            family_discrepancy_reg_next = '0;
            status_next                 = ST_NONE;
          end else begin
            if (id_bit != complement_bit) begin
              dir_next = id_bit;
            end else begin
              if (bit_position < last_discrepancy) begin
                dir_next = rom_bits[bit_idx];
              end else begin
                dir_next = (bit_position == last_discrepancy);
              end
              if (!dir_next) begin
                last_zero_pos_next = bit_position;
                if (bit_position < POS_WIDTH'(FAMILY_LIMIT)) begin
                  family_discrepancy_reg_next = bit_position[FAM_WIDTH-1:0];
                end
              end
            end
            rom_bits_next[bit_idx] = dir_next;
            status_next            = ST_DIR;
            if (bit_position >= POS_WIDTH'(SEARCH_BITS)) begin
              pass_active_next      = 1'b0;
              bit_position_next     = POS_WIDTH'(1);
              last_discrepancy_next = last_zero_pos_next;
              if (last_zero_pos_next == '0) begin
                last_device_flag_next = 1'b1;
              end
              if (rom_bits_next[7:0] == 8'd0) begin
                last_discrepancy_next       = '0;
                last_device_flag_next       = 1'b0;
                family_discrepancy_reg_next = '0;
                status_next                 = ST_NONE;
              end else begin
                status_next = ST_FOUND;
              end
            end else begin
              bit_position_next = bit_position + POS_WIDTH'(1);
            end
          end
        end
      end
      MODE_CLEAR: begin
        rom_bits_next               = '0;
        last_discrepancy_next       = '0;
        last_device_flag_next       = 1'b0;
        family_discrepancy_reg_next = '0;
        pass_active_next            = 1'b0;
        bit_position_next           = POS_WIDTH'(1);
        last_zero_pos_next          = '0;
        status_next                 = ST_CLEARED;
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits               <= '0;
      last_discrepancy       <= '0;
      family_discrepancy_reg <= '0;
      last_device_flag       <= 1'b0;
      bit_position           <= POS_WIDTH'(1);
      last_zero_pos          <= '0;
      pass_active            <= 1'b0;
    end else if (accept) begin
      rom_bits               <= rom_bits_next;
      last_discrepancy       <= last_discrepancy_next;
      family_discrepancy_reg <= family_discrepancy_reg_next;
      last_device_flag       <= last_device_flag_next;
      bit_position           <= bit_position_next;
      last_zero_pos          <= last_zero_pos_next;
      pass_active            <= pass_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status             <= status_next;
      direction          <= dir_next;
      rom_address        <= rom_bits_next;
      last_device        <= abort_last ? 1'b1 : last_device_flag_next;
      family_discrepancy <= family_discrepancy_reg_next;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the one_wire_rom_search ROM search engine.
`timescale 1ns / 100ps

module tb;
  import owrs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         ITEM_TARGET = 950;

  typedef struct packed {
    status_t                st;
    logic                   dir;
    logic [ROM_WIDTH-1:0]   rom;
    logic                   last;
    logic [FAM_WIDTH-1:0]   fam;
  } search_res_t;

  typedef struct {
    logic [1:0] md;
    logic       pres;
    logic       idb;
    logic       cmpb;
    bit         typed;
    status_t    st;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           mode;
  logic                 presence;
  logic                 id_bit;
  logic                 complement_bit;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           status;
  logic                 direction;
  logic [ROM_WIDTH-1:0] rom_address;
  logic                 last_device;
  logic [FAM_WIDTH-1:0] family_discrepancy;

  logic [ROM_WIDTH-1:0] srch_rom;
  logic [POS_WIDTH-1:0] srch_last_disc;
  logic [FAM_WIDTH-1:0] srch_fam;
  logic                 srch_last_dev;
  logic [POS_WIDTH-1:0] srch_pos;
  logic [POS_WIDTH-1:0] srch_last_zero;
  logic                 srch_active;

  search_res_t search_results[$];
  int          err_count = 0;
  int          busy_items = 0;
  int          idle_pct = 0;
  bit          long_hold = 1'b0;

  dir_row_t directed_rows [0:19] = '{
    '{MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b1, ST_IGNORED},
    '{MODE_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, ST_IGNORED},
    '{MODE_START,  1'b0, 1'b0, 1'b0, 1'b1, ST_NONE},
    '{MODE_CLEAR,  1'b1, 1'b1, 1'b1, 1'b1, ST_CLEARED},
    '{MODE_START,  1'b1, 1'b0, 1'b0, 1'b1, ST_BEGUN},
    '{MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b0, 1'b1, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b1, 1'b1, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b1, 1'b1, 1'b0, 1'b0, ST_DIR},
    '{MODE_START,  1'b1, 1'b0, 1'b0, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b0, ST_DIR},
    '{MODE_START,  1'b1, 1'b1, 1'b1, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b0, ST_DIR},
    '{MODE_BIT,    1'b0, 1'b0, 1'b1, 1'b0, ST_DIR},
    '{MODE_CLEAR,  1'b0, 1'b0, 1'b0, 1'b1, ST_CLEARED},
    '{MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b1, ST_IGNORED},
    '{MODE_START,  1'b1, 1'b0, 1'b1, 1'b1, ST_BEGUN},
    '{MODE_BIT,    1'b0, 1'b1, 1'b1, 1'b1, ST_NONE},
    '{MODE_UNUSED, 1'b0, 1'b0, 1'b0, 1'b1, ST_IGNORED}
  };

  one_wire_rom_search DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .mode               (mode),
    .presence           (presence),
    .id_bit             (id_bit),
    .complement_bit     (complement_bit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .direction          (direction),
    .rom_address        (rom_address),
    .last_device        (last_device),
    .family_discrepancy (family_discrepancy)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void drop_discrepancies();
    srch_last_disc = '0;
    srch_last_dev  = 1'b0;
    srch_fam       = '0;
  endfunction

  function automatic void clear_search_model();
    srch_rom       = '0;
    drop_discrepancies();
    srch_pos       = POS_WIDTH'(1);
    srch_last_zero = '0;
    srch_active    = 1'b0;
  endfunction

  function automatic search_res_t predict_search(input logic [1:0] md, input logic pres,
                                                 input logic idb, input logic cmpb);
    search_res_t          r;
    logic [POS_WIDTH-1:0] p;
    logic [5:0]           bit_idx;
    bit                   abort_last;
    r          = '0;
    r.st       = ST_IGNORED;
    abort_last = 1'b0;
    case (md)
      MODE_START: begin
        srch_active = 1'b0;
        if (srch_last_dev) begin
          drop_discrepancies();
          r.st       = ST_NONE;
          abort_last = 1'b1;
        end else if (!pres) begin
          drop_discrepancies();
          r.st = ST_NONE;
        end else begin
          srch_active    = 1'b1;
          srch_pos       = POS_WIDTH'(1);
          srch_last_zero = '0;
          r.st           = ST_BEGUN;
        end
      end
      MODE_BIT: begin
        if (srch_active) begin
          if (idb && cmpb) begin
            srch_active = 1'b0;
            drop_discrepancies();
            r.st = ST_NONE;
          end else begin
            p       = srch_pos;
            bit_idx = 6'(p - 1);
            if (idb != cmpb) begin
              r.dir = idb;
            end else begin
              if (p < srch_last_disc) r.dir = srch_rom[bit_idx];
              else r.dir = (p == srch_last_disc);
              if (!r.dir) begin
                srch_last_zero = p;
                if (p < FAMILY_LIMIT) srch_fam = p[FAM_WIDTH-1:0];
              end
            end
            srch_rom[bit_idx] = r.dir;
            r.st = ST_DIR;
            if (p >= ROM_WIDTH) begin
              srch_active    = 1'b0;
              srch_pos       = POS_WIDTH'(1);
              srch_last_disc = srch_last_zero;
              if (srch_last_disc == 0) srch_last_dev = 1'b1;
              if (srch_rom[7:0] == 0) begin
                drop_discrepancies();
                r.st = ST_NONE;
              end else begin
                r.st = ST_FOUND;
              end
            end else begin
              srch_pos = p + POS_WIDTH'(1);
            end
          end
        end
      end
      MODE_CLEAR: begin
        clear_search_model();
        r.st = ST_CLEARED;
      end
      default: ;
    endcase
    r.rom  = srch_rom;
    r.last = abort_last ? 1'b1 : srch_last_dev;
    r.fam  = srch_fam;
    return r;
  endfunction

  task automatic put_item(input logic [1:0] md, input logic pres, input logic idb,
                          input logic cmpb, output search_res_t res,
                          input bit typed = 1'b0, input status_t typed_st = ST_IGNORED);
    search_res_t want;
    res = predict_search(md, pres, idb, cmpb);
    if (res.st != ST_IGNORED) busy_items++;
    if (busy_items > ITEM_TARGET - 120) idle_pct = 0;
    want = res;
    if (typed) begin
      want    = '0;
      want.st = typed_st;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= md;
    presence       <= pres;
    id_bit         <= idb;
    complement_bit <= cmpb;
    do @(posedge clk); while (!in_ready);
    search_results.push_back(want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (search_results.size() != 0);
  endtask

  task automatic run_bus(input logic [ROM_WIDTH-1:0] devs[$]);
    search_res_t res;
    bit          alive[$];
    logic        idb;
    logic        cmpb;
    int          break_at;
    for (int pass = 0; pass < devs.size() + 2; pass++) begin
      put_item(MODE_START, devs.size() != 0, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), res);
      if (res.st != ST_BEGUN) return;
      alive = {};
      foreach (devs[d]) alive.push_back(1'b1);
      break_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 63) : ROM_WIDTH;
      for (int k = 0; k < ROM_WIDTH; k++) begin
        if (k == break_at) begin
          case ($urandom_range(0, 2))
            0:       put_item(MODE_BIT, 1'b0, 1'b1, 1'b1, res);
            1:       put_item(MODE_START, 1'($urandom_range(0, 1)), 1'b0, 1'b0, res);
            default: put_item(MODE_CLEAR, 1'b0, 1'b0, 1'b0, res);
          endcase
          break;
        end
        idb  = 1'b1;
        cmpb = 1'b1;
        foreach (devs[d]) begin
          if (alive[d]) begin
            if (devs[d][k]) cmpb = 1'b0;
            else idb = 1'b0;
          end
        end
        put_item(MODE_BIT, 1'b0, idb, cmpb, res);
        foreach (alive[d]) if (devs[d][k] != res.dir) alive[d] = 1'b0;
      end
    end
  endtask

  initial begin : stimulus
    search_res_t          res;
    logic [ROM_WIDTH-1:0] devs[$];
    logic [ROM_WIDTH-1:0] base;
    int                   ndev;
    int                   episode;
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_START;
    presence       = 1'b0;
    id_bit         = 1'b0;
    complement_bit = 1'b0;
    clear_search_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      put_item(directed_rows[i].md, directed_rows[i].pres, directed_rows[i].idb,
               directed_rows[i].cmpb, res, directed_rows[i].typed, directed_rows[i].st);
    wait_drained();

    devs = '{'0};
    run_bus(devs);
    devs = '{{ROM_WIDTH{1'b1}}};
    run_bus(devs);

    episode = 0;
    while (busy_items < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (busy_items > ITEM_TARGET - 120) idle_pct = 0;
      if (episode == 3) long_hold = 1'b1;
      if (episode == 6) wait_drained();
      if ($urandom_range(0, 9) < 7) begin
        ndev = $urandom_range(0, 4);
        base = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0) base[7:0] = '0;
        devs = {};
        for (int i = 0; i < ndev; i++) begin
          if (i == 0) devs.push_back(base);
          else if ($urandom_range(0, 1)) devs.push_back({$urandom, $urandom});
          else devs.push_back(base ^ ({$urandom, $urandom} &
                                      ({ROM_WIDTH{1'b1}} << $urandom_range(1, 63))));
        end
        run_bus(devs);
      end else begin
        repeat ($urandom_range(5, 20))
          put_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), res);
      end
      episode++;
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && search_results.size() != 0; n++) @(posedge clk);
    if (search_results.size() != 0) begin
      $error("%0d results never arrived", search_results.size());
      err_count++;
    end
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    search_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (search_results.size() == 0) begin
        $error("unexpected result: status %0d", status);
        err_count++;
      end else begin
        want = search_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          err_count++;
        end
        if (direction !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, direction);
          err_count++;
        end
        if (rom_address !== want.rom) begin
          $error("rom_address: expected %h, got %h", want.rom, rom_address);
          err_count++;
        end
        if (last_device !== want.last) begin
          $error("last_device: expected %0d, got %0d", want.last, last_device);
          err_count++;
        end
        if (family_discrepancy !== want.fam) begin
          $error("family_discrepancy: expected %0d, got %0d", want.fam, family_discrepancy);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ one_wire_rom_search.f @@
src/owrs_pkg.sv
src/one_wire_rom_search.sv
tb/sv/tb.sv
